// ----- rtl/lz77d_pkg.sv -----
`timescale 1ns / 1ps
// Package for the LZ77 type 0x10 decompressor core.
// Shared types, command format and codes. No dependencies.
package lz77d_pkg;

    localparam logic [7:0] HDR_MAGIC       = 8'h10;
    localparam logic [3:0] TOKENS_PER_FLAG = 4'd8;
    localparam logic [4:0] MIN_MATCH       = 5'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_HDR = 2'd1;
    localparam logic [1:0] ST_BAD_REF = 2'd2;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SIZE0,
        PH_SIZE1,
        PH_SIZE2,
        PH_TOKEN,
        PH_REF2,
        PH_DONE,
        PH_HALT
    } phase_t;

    typedef enum logic [1:0] {
        CMD_LIT,
        CMD_COPY,
        CMD_STAT
    } cmd_kind_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EMIT,
        BK_READ,
        BK_DATA
    } back_state_t;

    // One command per input byte that produces results.
    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  data;      // literal byte
        logic [4:0]  count;     // bytes to copy, already clipped to the declared size
        logic [11:0] copy_dist; // copy distance modulo the ring size
        logic        done;      // last result of this command completes the stream
        logic [1:0]  status;
    } cmd_t;

endpackage

// ----- rtl/lz77d_front.sv -----
`timescale 1ns / 1ps
// Stream parser: header, size, flag bytes and tokens; issues one command per
// result-producing beat. Depends on lz77d_pkg.
module lz77d_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [7:0]       data_byte,
    input  logic             stream_start,
    input  logic             q_full,
    output logic             in_stall,
    output logic             push,
    output lz77d_pkg::cmd_t  cmd
);
    import lz77d_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [23:0] size_reg, size_next;
    logic [23:0] prod_reg, prod_next;
    logic [7:0]  flags_reg, flags_next;
    logic [3:0]  tok_reg, tok_next;
    logic [7:0]  refhi_reg, refhi_next;

    phase_t      cur_phase;
    logic [23:0] cur_size;
    logic [23:0] cur_prod;
    logic [7:0]  cur_flags;
    logic [3:0]  cur_tok;
    logic        accept;
    logic [4:0]  ref_len;
    logic [12:0] ref_dist;
    logic [23:0] remaining;
    logic        ref_bad;
    logic        ref_clip;
    logic [4:0]  ref_count;

    assign accept   = in_valid && !q_full;
    assign in_stall = q_full;

    // stream_start restarts the parser on this very beat
    assign cur_phase = stream_start ? PH_HEADER : phase_reg;
    assign cur_size  = stream_start ? 24'd0 : size_reg;
    assign cur_prod  = stream_start ? 24'd0 : prod_reg;
    assign cur_flags = stream_start ? 8'd0 : flags_reg;
    assign cur_tok   = stream_start ? TOKENS_PER_FLAG : tok_reg;

    assign ref_len   = {1'b0, refhi_reg[7:4]} + MIN_MATCH;
    assign ref_dist  = {1'b0, refhi_reg[3:0], data_byte} + 13'd1;
    assign remaining = cur_size - cur_prod;
    assign ref_bad   = {11'd0, ref_dist} > cur_prod;
    assign ref_clip  = remaining <= {19'd0, ref_len};
    assign ref_count = ref_clip ? remaining[4:0] : ref_len;

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        size_next  = size_reg;
        prod_next  = prod_reg;
        flags_next = flags_reg;
        tok_next   = tok_reg;
        refhi_next = refhi_reg;
        if (accept)
        begin
            phase_next = cur_phase;
            size_next  = cur_size;
            prod_next  = cur_prod;
            flags_next = cur_flags;
            tok_next   = cur_tok;
            unique case (cur_phase)
                PH_HEADER:
                begin
                    phase_next = (data_byte == HDR_MAGIC) ? PH_SIZE0 : PH_HALT;
                end
                PH_SIZE0:
                begin
                    size_next  = {16'd0, data_byte};
                    phase_next = PH_SIZE1;
                end
                PH_SIZE1:
                begin
                    size_next  = {8'd0, data_byte, cur_size[7:0]};
                    phase_next = PH_SIZE2;
                end
                PH_SIZE2:
                begin
                    size_next  = {data_byte, cur_size[15:0]};
                    tok_next   = TOKENS_PER_FLAG;
                    phase_next = ({data_byte, cur_size[15:0]} == 24'd0) ? PH_DONE : PH_TOKEN;
                end
                PH_TOKEN:
                begin
                    if (cur_tok[3])
                    begin
                        flags_next = data_byte;
                        tok_next   = 4'd0;
                    end
                    else if (cur_flags[7])
                    begin
                        refhi_next = data_byte;
                        phase_next = PH_REF2;
                    end
                    else
                    begin
                        prod_next  = cur_prod + 24'd1;
                        flags_next = {cur_flags[6:0], 1'b0};
                        tok_next   = cur_tok + 4'd1;
                        if (remaining == 24'd1)
                            phase_next = PH_DONE;
                    end
                end
                PH_REF2:
                begin
                    if (ref_bad)
                        phase_next = PH_HALT;
                    else
                    begin
                        prod_next  = cur_prod + {19'd0, ref_count};
                        flags_next = {cur_flags[6:0], 1'b0};
                        tok_next   = cur_tok + 4'd1;
                        phase_next = ref_clip ? PH_DONE : PH_TOKEN;
                    end
                end
                PH_DONE, PH_HALT:
                begin
                    phase_next = cur_phase;
                end
            endcase
        end
    end

    // command outputs
    always_comb
    begin
        push          = 1'b0;
        cmd.kind      = CMD_STAT;
        cmd.data      = data_byte;
        cmd.count     = 5'd1;
        cmd.copy_dist = ref_dist[11:0];
        cmd.done      = 1'b0;
        cmd.status    = ST_OK;
        if (accept)
        begin
            unique case (cur_phase)
                PH_HEADER:
                begin
                    if (data_byte != HDR_MAGIC)
                    begin
                        push       = 1'b1;
                        cmd.status = ST_BAD_HDR;
                    end
                end
                PH_SIZE2:
                begin
                    if ({data_byte, cur_size[15:0]} == 24'd0)
                    begin
                        push     = 1'b1;
                        cmd.done = 1'b1;
                    end
                end
                PH_TOKEN:
                begin
                    if (!cur_tok[3] && !cur_flags[7])
                    begin
                        push     = 1'b1;
                        cmd.kind = CMD_LIT;
                        cmd.done = (remaining == 24'd1);
                    end
                end
                PH_REF2:
                begin
                    push = 1'b1;
                    if (ref_bad)
                        cmd.status = ST_BAD_REF;
                    else
                    begin
                        cmd.kind  = CMD_COPY;
                        cmd.count = ref_count;
                        cmd.done  = ref_clip;
                    end
                end
                PH_SIZE0, PH_SIZE1, PH_DONE, PH_HALT:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            size_reg  <= 24'd0;
            prod_reg  <= 24'd0;
            flags_reg <= 8'd0;
            tok_reg   <= TOKENS_PER_FLAG;
            refhi_reg <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            size_reg  <= size_next;
            prod_reg  <= prod_next;
            flags_reg <= flags_next;
            tok_reg   <= tok_next;
            refhi_reg <= refhi_next;
        end
    end

endmodule

// ----- rtl/lz77d_fifo.sv -----
`timescale 1ns / 1ps
// Two-entry command queue between parser and copy engine.
// Depends on lz77d_pkg.
module lz77d_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  lz77d_pkg::cmd_t  push_cmd,
    input  logic             pop,
    output lz77d_pkg::cmd_t  head,
    output logic             empty,
    output logic             full
);
    import lz77d_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign empty = (cnt_reg == 2'd0);
    assign full  = (cnt_reg == 2'd2);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("command pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("command popped from an empty queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("queue count out of range");

endmodule

// ----- rtl/lz77d_back.sv -----
`timescale 1ns / 1ps
// Copy engine: executes commands, owns the history ring and the output register.
// Depends on lz77d_pkg.
module lz77d_back #(
    parameter int HISTORY_DEPTH = 4096
) (
    input  logic             clk,
    input  logic             rst_n,
    input  lz77d_pkg::cmd_t  head,
    input  logic             empty,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       out_byte,
    output logic             byte_valid,
    output logic             run_last,
    output logic             stream_done,
    output logic [1:0]       status
);
    import lz77d_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);

    logic [7:0]  ring [HISTORY_DEPTH];
    logic [7:0]  ram_q_reg;

    back_state_t state_reg, state_next;
    cmd_t        cmd_reg;
    logic [4:0]  cnt_reg;
    logic [AW-1:0] wp_reg;

    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        byte_valid_reg;
    logic        run_last_reg;
    logic        stream_done_reg;
    logic [1:0]  status_reg;

    logic        out_free;
    logic        rd_en;
    logic        load_out;
    logic        ram_we;
    logic [AW-1:0] rd_addr;
    logic        last_copy;

    assign out_free  = !out_valid_reg || !out_stall;
    assign rd_addr   = wp_reg - AW'(cmd_reg.copy_dist);
    assign last_copy = (cnt_reg == 5'd1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!empty)
                    state_next = (head.kind == CMD_COPY) ? BK_READ : BK_EMIT;
            end
            BK_EMIT:
            begin
                if (out_free)
                    state_next = BK_IDLE;
            end
            BK_READ:
            begin
                state_next = BK_DATA;
            end
            BK_DATA:
            begin
                if (out_free)
                    state_next = last_copy ? BK_IDLE : BK_READ;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        pop      = (state_reg == BK_IDLE) && !empty;
        rd_en    = (state_reg == BK_READ);
        load_out = ((state_reg == BK_EMIT) || (state_reg == BK_DATA)) && out_free;
        ram_we   = load_out && (cmd_reg.kind != CMD_STAT);
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            ram_q_reg <= ring[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ram_we)
            ring[wp_reg] <= (state_reg == BK_DATA) ? ram_q_reg : cmd_reg.data;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cmd_reg <= head;
        if (load_out)
        begin
            out_byte_reg   <= 8'd0;
            byte_valid_reg <= 1'b0;
            run_last_reg   <= 1'b1;
            stream_done_reg <= cmd_reg.done;
            status_reg     <= cmd_reg.status;
            if (state_reg == BK_DATA)
            begin
                out_byte_reg    <= ram_q_reg;
                byte_valid_reg  <= 1'b1;
                run_last_reg    <= last_copy;
                stream_done_reg <= cmd_reg.done && last_copy;
            end
            else if (cmd_reg.kind == CMD_LIT)
            begin
                out_byte_reg   <= cmd_reg.data;
                byte_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            cnt_reg       <= 5'd0;
            wp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
                cnt_reg <= head.count;
            else if (load_out && (state_reg == BK_DATA))
                cnt_reg <= cnt_reg - 5'd1;
            if (ram_we)
                wp_reg <= wp_reg + AW'(1);
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign byte_valid  = byte_valid_reg;
    assign run_last    = run_last_reg;
    assign stream_done = stream_done_reg;
    assign status      = status_reg;

    a_copy_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_READ || state_reg == BK_DATA) |-> cnt_reg != 5'd0)
        else $error("copy running with zero count");

    a_data_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_READ) |=> (state_reg == BK_DATA))
        else $error("ring read not followed by data phase");

    a_write_only_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> load_out && (state_reg != BK_IDLE))
        else $error("history write without an output beat");

endmodule

// ----- rtl/lz77_type10_decompressor_core.sv -----
`timescale 1ns / 1ps
// Top level of the LZ77 type 0x10 decompressor core.
// Depends on lz77d_pkg, lz77d_front, lz77d_fifo, lz77d_back.

// Decompresses a GBA-style LZ77 type 0x10 stream fed one compressed byte per
// input beat. The parser takes one beat per cycle while its two-entry command
// queue has room; a valid header, size bytes (but for a zero size), flag and
// first reference bytes produce no result beat. A literal passes the copy
// engine as a queue pop and then an output load, a reference as a pop and,
// for each of its N output bytes (up to 18), a registered read of the
// single-port 4096-byte history ring followed by its write-back. Every result
// beat of an input byte except the last has run_last=0. Status-only beats
// (bad header, reference reaching before the stream start, zero declared
// size) carry byte_valid=0 and out_byte=0. Output ends at the declared size;
// trailing bytes and bytes after an error are dropped until stream_start.
// The history ring is not cleared at reset: reads only reach bytes already
// written in the current stream.
module lz77_type10_decompressor_core #(
    parameter int HISTORY_DEPTH = 4096
) (
    input  logic       clk,
    input  logic       rst_n,
    // compressed byte beats
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       stream_start,
    // decompressed result beats
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       run_last,
    output logic       stream_done,
    output logic [1:0] status
);
    import lz77d_pkg::*;

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    cmd_t push_cmd;
    cmd_t head_cmd;

    lz77d_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .data_byte    (data_byte),
        .stream_start (stream_start),
        .q_full       (q_full),
        .in_stall     (in_stall),
        .push         (q_push),
        .cmd          (push_cmd)
    );

    lz77d_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head     (head_cmd),
        .empty    (q_empty),
        .full     (q_full)
    );

    lz77d_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head_cmd),
        .empty       (q_empty),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .run_last    (run_last),
        .stream_done (stream_done),
        .status      (status)
    );

endmodule

// ----- sim/lz77_type10_decompressor_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for lz77_type10_decompressor_core.
// Depends on lz77d_pkg and the core. Directed streams first, then random streams.

module lz77_type10_decompressor_core_tb;
    import lz77d_pkg::*;

    // Upper bound on the run in clock cycles
    localparam int CYCLE_LIMIT   = 1000000;
    // Quiet cycles after the last result
    localparam int SETTLE_CYCLES = 64;
    // Input beats per random phase
    localparam int PHASE_BEATS   = 95;
    localparam int N_DIRECTED    = 23;

    // One result beat as the block presents it
    typedef struct packed {
        logic [7:0] b;
        logic       bv;
        logic       last;
        logic       done;
        logic [1:0] st;
    } beat_t;

    // One directed input beat; typed rows carry their result here, the others
    // are left to the decoder model
    typedef struct packed {
        logic [7:0] d;
        logic       s;
        logic       typed;
        logic       has_res;
        beat_t      res;
    } dir_row_t;

    localparam beat_t NO_BEAT = '0;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] data_byte = 8'h00;
    logic       stream_start = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       stream_done;
    logic [1:0] status;

    lz77_type10_decompressor_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .stream_start (stream_start),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .byte_valid   (byte_valid),
        .run_last     (run_last),
        .stream_done  (stream_done),
        .status       (status)
    );

    // Decoder model state, mirrors the block after each accepted beat
    logic [7:0]  hist_ring [0:4095];
    logic [11:0] wr_ptr;
    logic [23:0] out_count;
    logic [23:0] size_target;
    logic [7:0]  flag_reg;
    logic [3:0]  tok_idx;
    phase_t      parse_st;
    logic [7:0]  ref_hi;

    // Result beats still owed by the block, oldest first
    beat_t pending_beats [$];

    int mismatch_count = 0;
    int beats_checked  = 0;
    int n_sent         = 0;
    int n_streams      = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    // Beat count at which the current random phase stops sending
    int phase_end      = 0;

    // Directed streams:
    //   no stream_start after reset, literal, overlapping reference cut at the
    //   declared size, trailing byte ignored;
    //   bad header, then a byte dropped while halted;
    //   zero declared size;
    //   largest declared size, reference reaching before the stream start
    //   with the largest distance, then a byte dropped while halted.
    dir_row_t directed_rows [0:N_DIRECTED-1] = '{
        '{8'h10, 1'b0, 1'b1, 1'b0, NO_BEAT},
        '{8'h03, 1'b0, 1'b1, 1'b0, NO_BEAT},
        '{8'h00, 1'b0, 1'b1, 1'b0, NO_BEAT},
        '{8'h00, 1'b0, 1'b1, 1'b0, NO_BEAT},
        '{8'h40, 1'b0, 1'b1, 1'b0, NO_BEAT},
        '{8'hFF, 1'b0, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b0, ST_OK}},
        '{8'h00, 1'b0, 1'b1, 1'b0, NO_BEAT},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_BEAT},
        '{8'hAB, 1'b0, 1'b1, 1'b0, NO_BEAT},
        '{8'hEF, 1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, ST_BAD_HDR}},
        '{8'h10, 1'b0, 1'b1, 1'b0, NO_BEAT},
        '{8'h10, 1'b1, 1'b1, 1'b0, NO_BEAT},
        '{8'h00, 1'b0, 1'b1, 1'b0, NO_BEAT},
        '{8'h00, 1'b0, 1'b1, 1'b0, NO_BEAT},
        '{8'h00, 1'b0, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, ST_OK}},
        '{8'h10, 1'b1, 1'b1, 1'b0, NO_BEAT},
        '{8'hFF, 1'b0, 1'b1, 1'b0, NO_BEAT},
        '{8'hFF, 1'b0, 1'b1, 1'b0, NO_BEAT},
        '{8'hFF, 1'b0, 1'b1, 1'b0, NO_BEAT},
        '{8'hFF, 1'b0, 1'b1, 1'b0, NO_BEAT},
        '{8'hFF, 1'b0, 1'b1, 1'b0, NO_BEAT},
        '{8'hFF, 1'b0, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, ST_BAD_REF}},
        '{8'h55, 1'b0, 1'b1, 1'b0, NO_BEAT}
    };

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Decoder model
    // ---------------------------------------------------------------
    task automatic restart_stream();
        wr_ptr      = '0;
        out_count   = '0;
        size_target = '0;
        flag_reg    = '0;
        tok_idx     = TOKENS_PER_FLAG;
        parse_st    = PH_HEADER;
        ref_hi      = '0;
    endtask

    // Write one decoded byte to history and owe it; returns 1 on the final byte
    function automatic bit emit_byte(input logic [7:0] v);
        beat_t r;
        hist_ring[wr_ptr] = v;
        wr_ptr    = wr_ptr + 12'd1;
        out_count = out_count + 24'd1;
        r = '{v, 1'b1, 1'b0, (out_count == size_target), ST_OK};
        pending_beats.push_back(r);
        return r.done;
    endfunction

    task automatic status_beat(input logic [1:0] st, input logic done);
        pending_beats.push_back('{8'h00, 1'b0, 1'b1, done, st});
    endtask

    // Advance the model by one accepted input beat
    task automatic decode_byte(input logic [7:0] b, input logic s);
        int          len;
        logic [12:0] ref_dist;
        logic [11:0] src;
        if (s)
            restart_stream();
        case (parse_st)
            PH_HEADER:
            begin
                if (b != HDR_MAGIC)
                begin
                    parse_st = PH_HALT;
                    status_beat(ST_BAD_HDR, 1'b0);
                end
                else
                    parse_st = PH_SIZE0;
            end
            PH_SIZE0:
            begin
                size_target = {16'h0000, b};
                parse_st    = PH_SIZE1;
            end
            PH_SIZE1:
            begin
                size_target[15:8] = b;
                parse_st          = PH_SIZE2;
            end
            PH_SIZE2:
            begin
                size_target[23:16] = b;
                tok_idx            = TOKENS_PER_FLAG;
                if (size_target == '0)
                begin
                    parse_st = PH_DONE;
                    status_beat(ST_OK, 1'b1);
                end
                else
                    parse_st = PH_TOKEN;
            end
            PH_TOKEN:
            begin
                if (tok_idx >= TOKENS_PER_FLAG)
                begin
                    flag_reg = b;
                    tok_idx  = '0;
                end
                else if (flag_reg[7])
                begin
                    ref_hi   = b;
                    parse_st = PH_REF2;
                end
                else
                begin
                    if (emit_byte(b))
                        parse_st = PH_DONE;
                    pending_beats[pending_beats.size()-1].last = 1'b1;
                    flag_reg = flag_reg << 1;
                    tok_idx  = tok_idx + 4'd1;
                end
            end
            PH_REF2:
            begin
                len      = int'(ref_hi[7:4]) + int'(MIN_MATCH);
                ref_dist = {1'b0, ref_hi[3:0], b} + 13'd1;
                if (24'(ref_dist) > out_count)
                begin
                    parse_st = PH_HALT;
                    status_beat(ST_BAD_REF, 1'b0);
                end
                else
                begin
                    parse_st = PH_TOKEN;
                    // byte by byte, so an overlapping copy repeats fresh bytes
                    for (int i = 0; i < len; i++)
                    begin
                        src = wr_ptr - ref_dist[11:0];
                        if (emit_byte(hist_ring[src]))
                        begin
                            parse_st = PH_DONE;
                            break;
                        end
                    end
                    pending_beats[pending_beats.size()-1].last = 1'b1;
                    flag_reg = flag_reg << 1;
                    tok_idx  = tok_idx + 4'd1;
                end
            end
            default:
            begin
                // done or halted: byte dropped
            end
        endcase
    endtask

    // ---------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------
    // Offer one beat after a random gap; model it once it is taken.
    // A typed row replaces whatever the model owes for that beat.
    task automatic push_byte(input logic [7:0] d, input logic s,
                             input bit typed = 1'b0, input bit has_res = 1'b0,
                             input beat_t res = '0);
        int owed_before;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        data_byte    <= d;
        stream_start <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        owed_before = pending_beats.size();
        decode_byte(d, s);
        if (typed)
        begin
            while (pending_beats.size() > owed_before)
                void'(pending_beats.pop_back());
            if (has_res)
                pending_beats.push_back(res);
        end
        n_sent++;
    endtask

    // Sender holds off until every owed byte is out, then lets the block settle
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One random stream: mostly well-formed with random content, some bad
    // headers, zero sizes, aborted streams, bad references and trailing noise
    task automatic gen_stream();
        int          kind;
        int          size;
        int          prod;
        int          tokens;
        int          token_cap;
        int          len;
        int          back_dist;
        int          avail;
        bit          bad;
        logic [7:0]  fl;
        logic [11:0] code;
        kind = $urandom_range(99);
        n_streams++;
        if (kind < 6)
        begin
            fl = 8'($urandom_range(255));
            if (fl == HDR_MAGIC)
                fl = ~fl;
            push_byte(fl, 1'b1);
            repeat ($urandom_range(2)) push_byte(8'($urandom_range(255)), 1'b0);
            return;
        end
        if (kind < 10)
            size = 0;
        else if (kind < 18)
            size = $urandom_range(24'hFFFFFF, 24'h000400);
        else if (kind < 26)
            size = $urandom_range(300, 64);
        else
            size = $urandom_range(40, 1);
        token_cap = (kind >= 10 && kind < 18) ? $urandom_range(12, 1) : 1 << 30;
        push_byte(HDR_MAGIC, 1'b1);
        push_byte(size[7:0], 1'b0);
        push_byte(size[15:8], 1'b0);
        push_byte(size[23:16], 1'b0);
        prod   = 0;
        tokens = 0;
        // a stream still open when the phase budget runs out is left aborted
        while (size != 0 && prod < size && tokens < token_cap && n_sent < phase_end)
        begin
            fl = 8'($urandom_range(255));
            // start mostly with a literal so the stream gets going
            if ($urandom_range(9) != 0)
                fl[7] = 1'b0;
            push_byte(fl, 1'b0);
            for (int j = 7;
                 j >= 0 && prod < size && tokens < token_cap && n_sent < phase_end;
                 j--)
            begin
                tokens++;
                if (fl[j])
                begin
                    len   = $urandom_range(18, 3);
                    avail = (prod < 4096) ? prod : 4096;
                    bad   = (avail == 0) || ($urandom_range(39) == 0);
                    if (bad)
                        back_dist = $urandom_range(4096, prod + 1);
                    else if ($urandom_range(1) == 0)
                        back_dist = $urandom_range((avail < 4) ? avail : 4, 1);
                    else
                        back_dist = $urandom_range(avail, 1);
                    code = 12'(back_dist - 1);
                    push_byte({4'(len - 3), code[11:8]}, 1'b0);
                    push_byte(code[7:0], 1'b0);
                    prod += len;
                    if (bad)
                    begin
                        repeat ($urandom_range(2)) push_byte(8'($urandom_range(255)), 1'b0);
                        return;
                    end
                end
                else
                begin
                    push_byte(8'($urandom_range(255)), 1'b0);
                    prod++;
                end
            end
        end
        // trailing random bytes; those past the declared size are dropped by the block
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(3, 1)) push_byte(8'($urandom_range(255)), 1'b0);
    endtask

    // ---------------------------------------------------------------
    // Receiver side
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Every taken result beat is matched against the oldest owed one
    always @(posedge clk)
    begin : result_check
        beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_beats.size() == 0)
            begin
                $display({"%0t: unexpected result beat: expected none, ",
                          "got byte %0h valid %0b last %0b done %0b status %0d"},
                         $time, out_byte, byte_valid, run_last, stream_done, status);
                mismatch_count++;
            end
            else
            begin
                want = pending_beats.pop_front();
                check_field("out_byte", want.b, out_byte);
                check_field("byte_valid", {7'd0, want.bv}, {7'd0, byte_valid});
                check_field("run_last", {7'd0, want.last}, {7'd0, run_last});
                check_field("stream_done", {7'd0, want.done}, {7'd0, stream_done});
                check_field("status", {6'd0, want.st}, {6'd0, status});
                beats_checked++;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d result beats still owed",
                     cycle_count, pending_beats.size());
            $display("lz77_type10_decompressor_core_tb: FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin : main_seq
        int idle_tbl  [4];
        int stall_tbl [4];
        idle_tbl  = '{0, 50, 0, 36};
        stall_tbl = '{0, 0, 50, 36};
        // history contents do not matter: the model only reads bytes it wrote
        for (int i = 0; i < 4096; i++)
            hist_ring[i] = 8'h00;
        restart_stream();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows, first one without stream_start
        for (int i = 0; i < N_DIRECTED; i++)
            push_byte(directed_rows[i].d, directed_rows[i].s, directed_rows[i].typed,
                      directed_rows[i].has_res, directed_rows[i].res);
        drain_results();

        // random streams under each idling pattern; every phase ends with
        // the sender holding off until all owed bytes have come back
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = idle_tbl[p];
            recv_stall_pct = stall_tbl[p];
            phase_end = n_sent + PHASE_BEATS;
            while (n_sent < phase_end)
                gen_stream();
            drain_results();
        end

        $display("sent %0d compressed beats in %0d streams, checked %0d result beats",
                 n_sent, n_streams + 4, beats_checked);
        $display({"covered literals, overlapping and cut references, bad headers ",
                  "and references, idle and stall mixes"});
        if (mismatch_count == 0)
            $display("lz77_type10_decompressor_core_tb: PASS");
        else
            $display("lz77_type10_decompressor_core_tb: FAIL");
        $finish;
    end

endmodule

// ----- lz77_type10_decompressor_core.f -----
rtl/lz77d_pkg.sv
rtl/lz77d_front.sv
rtl/lz77d_fifo.sv
rtl/lz77d_back.sv
rtl/lz77_type10_decompressor_core.sv
sim/lz77_type10_decompressor_core_tb.sv
